/* rtl/window_anomaly_and_trend_assert.svh */
// ----------------------------------------------------------------------------
// window anomaly and trend assertion macros
// concurrent assertion helpers for the rtl of this block
// ----------------------------------------------------------------------------
`ifndef WINDOW_ANOMALY_AND_TREND_ASSERT_SVH
`define WINDOW_ANOMALY_AND_TREND_ASSERT_SVH

`ifndef ASSERT_OFF
`define WAT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define WAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WAT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WAT_ASSERT(lbl, clk, rst, prop)
`define WAT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WAT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/wat_pkg.sv */
// ----------------------------------------------------------------------------
// wat_pkg
// shared constants and types for the window anomaly and trend block
// ----------------------------------------------------------------------------
package wat_pkg;

  localparam int WINDOW = 10;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int SMP_W  = 15;
  localparam int PRD_W  = 18;
  localparam int FIL_W  = 4;
  localparam int CFG_W  = 4;

  localparam int DVD_W  = 42;
  localparam int DVS_W  = 24;

  localparam logic [0:0] REG_MIN_SAMPLES = 1'b0;
  localparam logic [0:0] REG_SIGMA_MULT  = 1'b1;

  localparam logic [CFG_W-1:0] MIN_SAMPLES_RST = CFG_W'(5);
  localparam logic [CFG_W-1:0] SIGMA_MULT_RST  = CFG_W'(2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    M_NX, M_SS, M_NQ, M_AA, M_KK, M_VK, M_XX, M_NSXX,
    M_XS, M_NSXY, M_NN, M_NUM, M_SD, M_DN, M_END
  } mstep_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* rtl/wat_if.sv */
// ----------------------------------------------------------------------------
// wat_in_if / wat_out_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
interface wat_in_if;
  logic                      valid;
  logic                      ready;
  logic [wat_pkg::SMP_W-1:0] sample;
  logic                      restart;
  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface wat_out_if;
  logic                             valid;
  logic                             ready;
  logic                             anomalous;
  logic signed [wat_pkg::PRD_W-1:0] predicted_next;
  logic [wat_pkg::FIL_W-1:0]        fill_count;
  modport source (output valid, anomalous, predicted_next, fill_count, input ready);
  modport sink   (input valid, anomalous, predicted_next, fill_count, output ready);
endinterface

/* rtl/wat_cell.sv */
// ----------------------------------------------------------------------------
// wat_cell
// one window slot: a sample and its held flag, loaded from the neighbor
// ----------------------------------------------------------------------------
module wat_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ce_i,
  input  logic                      held_i,
  input  logic [wat_pkg::SMP_W-1:0] data_i,
  output logic                      held_o,
  output logic [wat_pkg::SMP_W-1:0] data_o
);
  import wat_pkg::*;

  logic             held_q;
  logic [SMP_W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (ce_i) begin
      held_q <= held_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      data_q <= data_i;
    end
  end

  assign held_o = held_q;
  assign data_o = data_q;
endmodule

/* rtl/wat_div.sv */
// ----------------------------------------------------------------------------
// wat_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wat_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wat_pkg::DVD_W-1:0] dividend_i,
  input  logic [wat_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [wat_pkg::DVD_W-1:0] quotient_o
);
  import wat_pkg::*;

  localparam int BC_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BC_W-1:0]   bc_q, bc_d;
  logic [DVD_W-1:0]  qt_q, qt_d;
  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bc_d   = bc_q;
    qt_d   = qt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[DVS_W-1:0], qt_q[DVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      bc_d   = BC_W'(DVD_W);
      qt_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        qt_d  = {qt_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        qt_d  = {qt_q[DVD_W-2:0], 1'b0};
      end
      bc_d = bc_q - 1'b1;
      if (bc_q == BC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bc_q   <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qt_q  <= qt_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = qt_q;
endmodule

/* rtl/window_anomaly_and_trend.sv */
// ----------------------------------------------------------------------------
// window_anomaly_and_trend
// sliding window anomaly flag and least-squares forecast of usage samples
// ----------------------------------------------------------------------------
//   channel  dir  beat
//   smp_i    in   sample, restart
//   res_o    out  anomalous, predicted_next, fill_count
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// the divider runs only when the window holds two or more samples
// the scan circulates the cell row once, the sums run through one multiplier
// a new sample is taken while the previous result still waits in res_o
// reset empties the window and loads register defaults
// ----------------------------------------------------------------------------
`include "window_anomaly_and_trend_assert.svh"

module window_anomaly_and_trend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  wat_in_if.sink                    smp_i,
  wat_out_if.source                 res_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [wat_pkg::CFG_W-1:0] cfg_wdata_i
);
  import wat_pkg::*;

  state_e            st_q, st_d;
  mstep_e            step_q, step_d;
  logic [CFG_W-1:0]  min_q, sig_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  scan_q;
  logic [CNT_W-1:0]  idx_q;
  logic [SMP_W-1:0]  x_q;

  logic [19:0]       s_q;
  logic [34:0]       q_q;
  logic [8:0]        sx_q;
  logic [13:0]       sxx_q;
  logic [23:0]       sxy_q;

  logic [20:0]       ad_q;
  logic [41:0]       adsq_q;
  logic signed [41:0] var_q;
  logic signed [63:0] t_q;
  logic [19:0]       den_q;
  logic signed [41:0] num_q;
  logic signed [42:0] top_q;
  logic              flag_q;

  logic signed [41:0] ma;
  logic signed [21:0] mb;
  logic signed [63:0] p_q;

  logic              ovld_q;
  logic              oanom_q;
  logic signed [PRD_W-1:0] opred_q;
  logic [FIL_W-1:0]  ofill_q;

  logic              in_acc, out_free, shift_en;
  logic [WINDOW-1:0] held_v, nh;
  logic [SMP_W-1:0]  cd [WINDOW];
  logic [SMP_W-1:0]  nd [WINDOW];
  logic [SMP_W-1:0]  y0;
  logic              h0;
  div_ctl_t          dctl;
  logic [DVD_W-1:0]  quot;
  logic [DVD_W-1:0]  top_mag;
  logic signed [PRD_W-1:0] pred;
  logic signed [63:0] p_d;

  assign in_acc   = smp_i.valid && smp_i.ready;
  assign out_free = !ovld_q || res_o.ready;
  assign smp_i.ready = (st_q == ST_IDLE);
  assign shift_en = in_acc || (st_q == ST_SCAN);
  assign y0 = cd[0];
  assign h0 = held_v[0];

  // cell row: push shifts toward cell 0, scan rotates the row once
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    if (g == WINDOW - 1) begin : g_last
      assign nd[g] = (st_q == ST_SCAN) ? cd[0] : smp_i.sample;
      assign nh[g] = (st_q == ST_SCAN) ? held_v[0] : 1'b1;
    end else begin : g_mid
      assign nd[g] = cd[g+1];
      assign nh[g] = (st_q == ST_SCAN) ? held_v[g+1] : (held_v[g+1] & ~smp_i.restart);
    end
    wat_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ce_i   (shift_en),
      .held_i (nh[g]),
      .data_i (nd[g]),
      .held_o (held_v[g]),
      .data_o (cd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_SAMPLES_RST;
      sig_q <= SIGMA_MULT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_SAMPLES: min_q <= cfg_wdata_i;
        REG_SIGMA_MULT:  sig_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      M_NX:   begin ma = 42'(x_q);   mb = 22'(cnt_q); end
      M_SS:   begin ma = 42'(s_q);   mb = 22'(s_q);   end
      M_NQ:   begin ma = 42'(q_q);   mb = 22'(cnt_q); end
      M_AA:   begin ma = 42'(ad_q);  mb = 22'(ad_q);  end
      M_KK:   begin ma = 42'(sig_q); mb = 22'(sig_q); end
      M_VK:   begin ma = var_q;      mb = p_q[21:0];  end
      M_XX:   begin ma = 42'(sx_q);  mb = 22'(sx_q);  end
      M_NSXX: begin ma = 42'(sxx_q); mb = 22'(cnt_q); end
      M_XS:   begin ma = 42'(s_q);   mb = 22'(sx_q);  end
      M_NSXY: begin ma = 42'(sxy_q); mb = 22'(cnt_q); end
      M_NN:   begin ma = 42'(cnt_q); mb = 22'(cnt_q); end
      M_NUM:  begin ma = num_q;      mb = 22'(p_q - 64'(sx_q)); end
      M_SD:   begin ma = 42'(s_q);   mb = 22'(den_q); end
      M_DN:   begin ma = 42'(den_q); mb = 22'(cnt_q); end
      default: ;
    endcase
  end

  assign p_d = 64'(ma) * 64'(mb);

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    unique case (st_q)
      ST_IDLE: if (in_acc) st_d = ST_SCAN;
      ST_SCAN: if (scan_q == IDX_W'(WINDOW - 1)) begin
        st_d   = ST_MUL;
        step_d = M_NX;
      end
      ST_MUL: begin
        if (step_q == M_END) begin
          st_d = (cnt_q >= CNT_W'(2)) ? ST_DIV : ST_FIN;
        end else begin
          step_d = mstep_e'(step_q + 4'd1);
        end
      end
      ST_DIV: if (dctl.done) st_d = ST_FIN;
      ST_FIN: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= M_NX;
      cnt_q  <= '0;
      scan_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      if (in_acc) begin
        cnt_q <= smp_i.restart ? CNT_W'(1)
               : (cnt_q == CNT_W'(WINDOW)) ? cnt_q : cnt_q + 1'b1;
      end
      scan_q <= (st_q == ST_SCAN) ? scan_q + 1'b1 : '0;
      if (st_q == ST_FIN && out_free) begin
        ovld_q <= 1'b1;
      end else if (res_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (in_acc) begin
      x_q   <= smp_i.sample;
      s_q   <= '0;
      q_q   <= '0;
      sx_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      idx_q <= '0;
    end
    if (st_q == ST_SCAN && h0) begin
      s_q   <= s_q + 20'(y0);
      q_q   <= q_q + 35'(30'(y0) * 30'(y0));
      sx_q  <= sx_q + 9'(idx_q);
      sxx_q <= sxx_q + 14'(10'(idx_q) * 10'(idx_q));
      sxy_q <= sxy_q + 24'(24'(idx_q) * 24'(y0));
      idx_q <= idx_q + 1'b1;
    end
    if (st_q == ST_MUL) begin
      case (step_q)
        M_SS:   ad_q   <= (p_q >= 64'(s_q)) ? 21'(p_q - 64'(s_q)) : 21'(64'(s_q) - p_q);
        M_NQ:   t_q    <= p_q;
        M_AA:   var_q  <= 42'(p_q - t_q);
        M_KK:   adsq_q <= p_q[41:0];
        M_XX:   flag_q <= (6'(cnt_q) >= 6'(min_q)) && (64'(adsq_q) > p_q);
        M_NSXX: t_q    <= p_q;
        M_XS:   den_q  <= 20'(p_q - t_q);
        M_NSXY: t_q    <= p_q;
        M_NN:   num_q  <= 42'(p_q - t_q);
        M_SD:   t_q    <= p_q;
        M_DN:   top_q  <= 43'(t_q + p_q);
        default: ;
      endcase
    end
    if (st_q == ST_FIN && out_free) begin
      oanom_q <= flag_q;
      opred_q <= pred;
      ofill_q <= FIL_W'(cnt_q);
    end
  end

  assign top_mag    = top_q[42] ? DVD_W'(-top_q) : DVD_W'(top_q);
  assign dctl.start = (st_q == ST_MUL) && (step_q == M_END) && (cnt_q >= CNT_W'(2));

  // divisor n * den is the product present in the last multiply step
  wat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dctl.start),
    .dividend_i (top_mag),
    .divisor_i  (p_q[DVS_W-1:0]),
    .busy_o     (dctl.busy),
    .done_o     (dctl.done),
    .quotient_o (quot)
  );

  // truncate toward zero, then saturate; below two samples the latest sample passes through
  always_comb begin
    if (cnt_q < CNT_W'(2)) begin
      pred = PRD_W'(x_q);
    end else if (!top_q[42]) begin
      pred = (quot > DVD_W'(131071)) ? PRD_W'(131071) : PRD_W'(quot);
    end else begin
      pred = (quot > DVD_W'(131072)) ? PRD_W'(-131072) : PRD_W'(-quot);
    end
  end

  assign res_o.valid          = ovld_q;
  assign res_o.anomalous      = oanom_q;
  assign res_o.predicted_next = opred_q;
  assign res_o.fill_count     = ofill_q;

  `WAT_ASSERT(a_cnt_max, clk_i, !rst_ni, cnt_q <= CNT_W'(WINDOW))
  `WAT_ASSERT_IMP(a_held_cnt, clk_i, !rst_ni, st_q == ST_IDLE, $countones(held_v) == 32'(cnt_q))
  `WAT_ASSERT_NXT(a_acc_scan, clk_i, !rst_ni, in_acc, st_q == ST_SCAN)
  `WAT_ASSERT_IMP(a_div_state, clk_i, !rst_ni, dctl.busy, st_q == ST_DIV)
  `WAT_ASSERT_IMP(a_scan_count, clk_i, !rst_ni, st_q == ST_MUL && step_q == M_NX, 32'(idx_q) == 32'(cnt_q))
endmodule
